[hdl/rbl3_pkg.sv]
// Shared types, constants and sizes of the 3-D raster blob labeler.
`default_nettype none
package rbl3_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int LABEL_BITS = 16;

  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int DEPTH     = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int OUT_LBL_W = 16;
  localparam int DIM_W     = 11;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [LABEL_BITS-1:0] LABEL_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd2;

  localparam logic signed [CFG_W-1:0] THRESHOLD_RESET = 32'sd196608;

  typedef enum logic [2:0] {
    NB_NONE, NB_L, NB_T, NB_TL, NB_P, NB_LP, NB_TP, NB_ALL
  } nbr_code_t;

  typedef struct packed {
    logic signed [31:0] pixel_value;
    logic               start_of_scan;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_LBL_W-1:0] pixel_label;
    logic                 is_new_label;
    logic [1:0]           pair_count;
    logic [OUT_LBL_W-1:0] pair0_high;
    logic [OUT_LBL_W-1:0] pair0_low;
    logic [OUT_LBL_W-1:0] pair1_high;
    logic [OUT_LBL_W-1:0] pair1_low;
    logic [OUT_LBL_W-1:0] pair2_high;
    logic [OUT_LBL_W-1:0] pair2_low;
    logic                 label_overflow;
  } out_beat_t;

  typedef struct packed {
    logic              foreground;
    logic              start_of_scan;
    logic              col_zero;
    logic              row_zero;
    logic              first_frame;
    logic [ADDR_W-1:0] here_addr;
    logic [ADDR_W-1:0] top_addr;
  } scan_info_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [LABEL_BITS-1:0] data;
  } store_wr_t;

endpackage
`default_nettype wire

[hdl/rbl3_ram.sv]
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module rbl3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

[hdl/rbl3_scan.sv]
// Scan position tracking, foreground test and store address generation.
`default_nettype none
module rbl3_scan (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire rbl3_pkg::in_beat_t                pixel,
  input  wire logic signed [rbl3_pkg::CFG_W-1:0] threshold,
  input  wire logic [rbl3_pkg::COL_CNT_W-1:0]    cols,
  input  wire logic [rbl3_pkg::ROW_CNT_W-1:0]    rows,
  output rbl3_pkg::scan_info_t                   info
);

  logic [rbl3_pkg::COL_W-1:0]  column_count, column_count_next, base_col;
  logic [rbl3_pkg::ROW_W-1:0]  row_count, row_count_next, base_row;
  logic                        in_first_frame, in_first_frame_next, base_first;
  logic [rbl3_pkg::ADDR_W-1:0] here;

  always_comb begin
    base_col   = pixel.start_of_scan ? '0 : column_count;
    base_row   = pixel.start_of_scan ? '0 : row_count;
    base_first = pixel.start_of_scan ? 1'b1 : in_first_frame;

    column_count_next   = base_col;
    row_count_next      = base_row;
    in_first_frame_next = base_first;
    if (rbl3_pkg::COL_CNT_W'(base_col) + rbl3_pkg::COL_CNT_W'(1) >= cols) begin
      column_count_next = '0;
      if (rbl3_pkg::ROW_CNT_W'(base_row) + rbl3_pkg::ROW_CNT_W'(1) >= rows) begin
        row_count_next      = '0;
        in_first_frame_next = 1'b0;
      end else begin
        row_count_next = base_row + 1'b1;
      end
    end else begin
      column_count_next = base_col + 1'b1;
    end

    here = rbl3_pkg::ADDR_W'(base_row) * rbl3_pkg::ADDR_W'(rbl3_pkg::MAX_COLS)
         + rbl3_pkg::ADDR_W'(base_col);

    info.foreground    = !(pixel.pixel_value < threshold);
    info.start_of_scan = pixel.start_of_scan;
    info.col_zero      = (base_col == '0);
    info.row_zero      = (base_row == '0);
    info.first_frame   = base_first;
    info.here_addr     = here;
    info.top_addr      = here - rbl3_pkg::ADDR_W'(rbl3_pkg::MAX_COLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      row_count      <= '0;
      in_first_frame <= 1'b1;
    end else if (accept) begin
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      in_first_frame <= in_first_frame_next;
    end
  end

endmodule
`default_nettype wire

[hdl/rbl3_label.sv]
// Label decision stage with store forwarding, label counter and output register.
`default_nettype none
module rbl3_label (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire rbl3_pkg::scan_info_t                 info,
  input  wire logic [rbl3_pkg::LABEL_BITS-1:0]      rd_prev,
  input  wire logic [rbl3_pkg::LABEL_BITS-1:0]      rd_top,
  output logic                                      take,
  output rbl3_pkg::store_wr_t                       wr,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output rbl3_pkg::out_beat_t                       out_data
);

  localparam int LW = rbl3_pkg::LABEL_BITS;
  localparam int OW = rbl3_pkg::OUT_LBL_W;

  rbl3_pkg::scan_info_t s1;
  logic                 s1_valid, s1_adv;
  logic                 fwd_prev, fwd_top;
  logic [LW-1:0]        wr_label, left_label, label_counter;

  logic [LW-1:0]        lft, top, prev, label, cnt_base, cnt_next;
  logic                 fresh;
  logic [1:0]           npairs;
  logic [LW-1:0]        ph [3];
  logic [LW-1:0]        pl [3];
  rbl3_pkg::nbr_code_t  code;
  rbl3_pkg::out_beat_t  result;

  function automatic logic [LW-1:0] hi_of(input logic [LW-1:0] a, input logic [LW-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [LW-1:0] lo_of(input logic [LW-1:0] a, input logic [LW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign s1_adv = s1_valid && (!out_valid || out_ready);
  assign take   = !s1_valid || s1_adv;

  always_comb begin
    lft  = s1.col_zero ? '0 : left_label;
    top  = s1.row_zero ? '0 : (fwd_top ? wr_label : rd_top);
    prev = s1.first_frame ? '0 : (fwd_prev ? wr_label : rd_prev);
    code = rbl3_pkg::nbr_code_t'({prev != '0, top != '0, lft != '0});
    cnt_base = s1.start_of_scan ? '0 : label_counter;
    cnt_next = cnt_base;
    fresh    = 1'b0;
    label    = '0;
    npairs   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      ph[i] = '0;
      pl[i] = '0;
    end

    if (s1.foreground) begin
      case (code)
        rbl3_pkg::NB_NONE: begin
          if (cnt_base != rbl3_pkg::LABEL_MAX) begin
            cnt_next = cnt_base + 1'b1;
            fresh    = 1'b1;
          end
          label = cnt_next;
        end
        rbl3_pkg::NB_L: label = lft;
        rbl3_pkg::NB_T: label = top;
        rbl3_pkg::NB_TL: begin
          label = top;
          if (top != lft) begin
            ph[0] = hi_of(top, lft);
            pl[0] = lo_of(top, lft);
            npairs = 2'd1;
          end
        end
        rbl3_pkg::NB_P: label = prev;
        rbl3_pkg::NB_LP: begin
          label = lft;
          if (lft != prev) begin
            ph[0] = hi_of(lft, prev);
            pl[0] = lo_of(lft, prev);
            npairs = 2'd1;
          end
        end
        rbl3_pkg::NB_TP: begin
          label = top;
          if (top != prev) begin
            ph[0] = hi_of(top, prev);
            pl[0] = lo_of(top, prev);
            npairs = 2'd1;
          end
        end
        default: begin
          label = lft;
          if (top == lft && top != prev) begin
            ph[0] = hi_of(top, prev);
            pl[0] = lo_of(top, prev);
            npairs = 2'd1;
          end else if (top == prev && top != lft) begin
            ph[0] = hi_of(top, lft);
            pl[0] = lo_of(top, lft);
            npairs = 2'd1;
          end else if (lft == prev && lft != top) begin
            ph[0] = hi_of(lft, top);
            pl[0] = lo_of(lft, top);
            npairs = 2'd1;
          end else if (lft != prev && lft != top && top != prev) begin
            ph[0] = hi_of(top, prev);
            pl[0] = lo_of(top, prev);
            ph[1] = hi_of(top, lft);
            pl[1] = lo_of(top, lft);
            ph[2] = hi_of(lft, prev);
            pl[2] = lo_of(lft, prev);
            npairs = 2'd3;
          end
        end
      endcase
    end

    result.pixel_label    = OW'(label);
    result.is_new_label   = fresh;
    result.pair_count     = npairs;
    result.pair0_high     = OW'(ph[0]);
    result.pair0_low      = OW'(pl[0]);
    result.pair1_high     = OW'(ph[1]);
    result.pair1_low      = OW'(pl[1]);
    result.pair2_high     = OW'(ph[2]);
    result.pair2_low      = OW'(pl[2]);
    result.label_overflow = (cnt_next == rbl3_pkg::LABEL_MAX);

    wr.en   = s1_adv;
    wr.addr = s1.here_addr;
    wr.data = label;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      left_label    <= '0;
      label_counter <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid     <= 1'b1;
        left_label    <= label;
        label_counter <= cnt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= info;
      fwd_prev <= s1_valid && (s1.here_addr == info.here_addr);
      fwd_top  <= s1_valid && (s1.here_addr == info.top_addr);
    end
    if (s1_adv) begin
      wr_label <= label;
      out_data <= result;
    end
  end

  a_new_has_no_pairs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.is_new_label && out_data.pair_count != 2'd0))
    else $error("fresh label reported together with equivalence pairs");

  a_background_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pixel_label == '0 |->
      out_data.pair_count == 2'd0 && !out_data.is_new_label)
    else $error("background result carries pairs or a fresh label");

  a_counter_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1.start_of_scan |=> label_counter >= $past(label_counter))
    else $error("label counter went backwards within a scan");

  a_fresh_is_counter: assert property (@(posedge clk) disable iff (rst)
    s1_adv && fresh |=> label_counter == $past(label) && left_label == $past(label))
    else $error("fresh label does not match the label counter");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !accept)
    else $error("new beat taken while the label stage is stalled");

endmodule
`default_nettype wire

[hdl/raster_blob_labeler_3d_unit.sv]
// Top level of the 3-D raster blob labeler: config registers, label store and stages.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | input     | in_valid / in_ready    | in_data (rbl3_pkg::in_beat_t)
//  out     | output    | out_valid / out_ready  | out_data (rbl3_pkg::out_beat_t)
//  cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// One pixel per cycle when not stalled; results pass the label and output registers.
// The label store is read at the take edge and written when the label stage hands
// its result to the output register; a read of the address being written is forwarded.
// Reset is synchronous; the store holds no reset and needs no clearing pass.
// A stalled output holds the label stage, and the input stalls only when both are full.
`default_nettype none
module raster_blob_labeler_3d_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire rbl3_pkg::in_beat_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output rbl3_pkg::out_beat_t                      out_data,
  input  wire logic                                cfg_write,
  input  wire logic [rbl3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rbl3_pkg::CFG_W-1:0]          cfg_data
);

  logic signed [rbl3_pkg::CFG_W-1:0]     threshold;
  logic [rbl3_pkg::COL_CNT_W-1:0]        cols, cols_next;
  logic [rbl3_pkg::ROW_CNT_W-1:0]        rows, rows_next;
  logic [rbl3_pkg::DIM_W-1:0]            dim;
  logic                                  accept;
  rbl3_pkg::scan_info_t                  info;
  rbl3_pkg::store_wr_t                   wr;
  logic [rbl3_pkg::LABEL_BITS-1:0]       rd_prev, rd_top;

  assign accept = in_valid && in_ready;
  assign dim    = cfg_data[rbl3_pkg::DIM_W-1:0];

  always_comb begin
    if (dim == '0) begin
      cols_next = rbl3_pkg::COL_CNT_W'(1);
      rows_next = rbl3_pkg::ROW_CNT_W'(1);
    end else begin
      cols_next = (32'(dim) > rbl3_pkg::MAX_COLS) ?
                  rbl3_pkg::COL_CNT_W'(rbl3_pkg::MAX_COLS) : rbl3_pkg::COL_CNT_W'(dim);
      rows_next = (32'(dim) > rbl3_pkg::MAX_ROWS) ?
                  rbl3_pkg::ROW_CNT_W'(rbl3_pkg::MAX_ROWS) : rbl3_pkg::ROW_CNT_W'(dim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rbl3_pkg::THRESHOLD_RESET;
      cols      <= rbl3_pkg::COL_CNT_W'(rbl3_pkg::MAX_COLS);
      rows      <= rbl3_pkg::ROW_CNT_W'(rbl3_pkg::MAX_ROWS);
    end else if (cfg_write) begin
      case (cfg_index)
        rbl3_pkg::REG_THRESHOLD: threshold <= cfg_data;
        rbl3_pkg::REG_COLS:      cols      <= cols_next;
        rbl3_pkg::REG_ROWS:      rows      <= rows_next;
        default: ;
      endcase
    end
  end

  rbl3_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (in_data),
    .threshold (threshold),
    .cols      (cols),
    .rows      (rows),
    .info      (info)
  );

  rbl3_ram #(
    .WIDTH (rbl3_pkg::LABEL_BITS),
    .DEPTH (rbl3_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (accept),
    .raddr_a (info.here_addr),
    .raddr_b (info.top_addr),
    .rdata_a (rd_prev),
    .rdata_b (rd_top)
  );

  rbl3_label u_label (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .info      (info),
    .rd_prev   (rd_prev),
    .rd_top    (rd_top),
    .take      (in_ready),
    .wr        (wr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[sim/raster_blob_labeler_3d_unit_tb.sv]
// Self-checking testbench for the 3-D raster blob labeler with a built-in label predictor.
`timescale 1ns / 1ps
module testbench;

  localparam longint PIX_MIN = -(64'sd1 <<< 31);
  localparam longint PIX_MAX = (64'sd1 <<< 31) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1070;

  typedef struct packed {
    rbl3_pkg::in_beat_t  beat;
    logic                typed;
    rbl3_pkg::out_beat_t want;
  } pixel_job_t;

  typedef struct packed {
    logic                           is_cfg;
    logic [rbl3_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                    val;
    logic                           sos;
    logic                           typed;
    logic [rbl3_pkg::OUT_LBL_W-1:0] lbl;
    logic                           fresh;
    logic                           ovf;
  } scan_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rbl3_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rbl3_pkg::out_beat_t out_data;
  logic cfg_write = 1'b0;
  logic [rbl3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rbl3_pkg::CFG_W-1:0] cfg_data = '0;

  raster_blob_labeler_3d_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state and register copies.
  logic [31:0] fg_threshold;
  logic [rbl3_pkg::DIM_W-1:0] cols_reg;
  logic [rbl3_pkg::DIM_W-1:0] rows_reg;
  logic [rbl3_pkg::LABEL_BITS-1:0] lbl_store [0:rbl3_pkg::DEPTH-1];
  logic [rbl3_pkg::LABEL_BITS-1:0] left_lbl;
  logic [rbl3_pkg::COL_W-1:0] col_pos;
  logic [rbl3_pkg::ROW_W-1:0] row_pos;
  logic first_frame;
  logic [rbl3_pkg::LABEL_BITS-1:0] label_ctr;

  pixel_job_t pixel_q[$];
  rbl3_pkg::out_beat_t pending_labels[$];
  scan_step_t scan_steps[$];
  int mismatch_cnt = 0;
  int hold_asks = 0;

  function automatic int dim_eff(input logic [rbl3_pkg::DIM_W-1:0] v, input int maxv);
    if (v < 1) return 1;
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  function automatic void step_position();
    if (int'(col_pos) + 1 >= dim_eff(cols_reg, rbl3_pkg::MAX_COLS)) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= dim_eff(rows_reg, rbl3_pkg::MAX_ROWS)) begin
        row_pos = '0;
        first_frame = 1'b0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic logic [2*rbl3_pkg::LABEL_BITS-1:0] pair_of(
      input logic [rbl3_pkg::LABEL_BITS-1:0] a,
      input logic [rbl3_pkg::LABEL_BITS-1:0] b);
    return (a > b) ? {a, b} : {b, a};
  endfunction

  function automatic rbl3_pkg::out_beat_t label_pixel(input rbl3_pkg::in_beat_t px);
    rbl3_pkg::out_beat_t res;
    int here;
    int np;
    logic [rbl3_pkg::LABEL_BITS-1:0] lft, top, prv, lbl;
    logic [2*rbl3_pkg::LABEL_BITS-1:0] pr [3];
    rbl3_pkg::nbr_code_t code;
    res = '0;
    np = 0;
    lbl = '0;
    pr[0] = '0;
    pr[1] = '0;
    pr[2] = '0;
    if (px.start_of_scan) begin
      col_pos = '0;
      row_pos = '0;
      first_frame = 1'b1;
      label_ctr = '0;
    end
    here = int'(row_pos) * rbl3_pkg::MAX_COLS + int'(col_pos);
    if ($signed(px.pixel_value) < $signed(fg_threshold)) begin
      lbl_store[here] = '0;
      left_lbl = '0;
    end else begin
      lft = (col_pos == 0) ? '0 : left_lbl;
      top = (row_pos == 0) ? '0 : lbl_store[here - rbl3_pkg::MAX_COLS];
      prv = first_frame ? '0 : lbl_store[here];
      code = rbl3_pkg::nbr_code_t'({prv != '0, top != '0, lft != '0});
      case (code)
        rbl3_pkg::NB_NONE: begin
          if (label_ctr != rbl3_pkg::LABEL_MAX) begin
            label_ctr = label_ctr + 1'b1;
            res.is_new_label = 1'b1;
          end
          lbl = label_ctr;
        end
        rbl3_pkg::NB_L: lbl = lft;
        rbl3_pkg::NB_T: lbl = top;
        rbl3_pkg::NB_P: lbl = prv;
        rbl3_pkg::NB_TL: begin
          lbl = top;
          if (top != lft) begin
            pr[np] = pair_of(top, lft);
            np++;
          end
        end
        rbl3_pkg::NB_LP: begin
          lbl = lft;
          if (lft != prv) begin
            pr[np] = pair_of(lft, prv);
            np++;
          end
        end
        rbl3_pkg::NB_TP: begin
          lbl = top;
          if (top != prv) begin
            pr[np] = pair_of(top, prv);
            np++;
          end
        end
        default: begin
          lbl = lft;
          if (top == lft && top != prv) begin
            pr[0] = pair_of(top, prv);
            np = 1;
          end else if (top == prv && top != lft) begin
            pr[0] = pair_of(top, lft);
            np = 1;
          end else if (lft == prv && lft != top) begin
            pr[0] = pair_of(lft, top);
            np = 1;
          end else if (lft != prv && lft != top && top != prv) begin
            pr[0] = pair_of(top, prv);
            pr[1] = pair_of(top, lft);
            pr[2] = pair_of(lft, prv);
            np = 3;
          end
        end
      endcase
      lbl_store[here] = lbl;
      left_lbl = lbl;
      res.pixel_label = lbl;
      res.pair_count = 2'(np);
      res.pair0_high = pr[0][2*rbl3_pkg::LABEL_BITS-1 -: rbl3_pkg::LABEL_BITS];
      res.pair0_low = pr[0][rbl3_pkg::LABEL_BITS-1:0];
      res.pair1_high = pr[1][2*rbl3_pkg::LABEL_BITS-1 -: rbl3_pkg::LABEL_BITS];
      res.pair1_low = pr[1][rbl3_pkg::LABEL_BITS-1:0];
      res.pair2_high = pr[2][2*rbl3_pkg::LABEL_BITS-1 -: rbl3_pkg::LABEL_BITS];
      res.pair2_low = pr[2][rbl3_pkg::LABEL_BITS-1:0];
    end
    res.label_overflow = (label_ctr == rbl3_pkg::LABEL_MAX);
    step_position();
    return res;
  endfunction

  function automatic logic [31:0] pick_pixel(input logic fg);
    longint lo, hi, thr_l, pv;
    bit [63:0] r;
    bit near;
    r = {$urandom, $urandom};
    near = ($urandom_range(0, 3) == 0);
    thr_l = longint'($signed(fg_threshold));
    if (fg || thr_l == PIX_MIN) begin
      lo = thr_l;
      hi = PIX_MAX;
      if (near && lo + 3 < hi) hi = lo + 3;
    end else begin
      lo = PIX_MIN;
      hi = thr_l - 1;
      if (near && hi - 3 > lo) lo = hi - 3;
    end
    pv = lo + longint'(r % $unsigned(hi - lo + 1));
    return pv[31:0];
  endfunction

  function automatic scan_step_t cfg_step(input logic [rbl3_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
    scan_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic scan_step_t pix_step(input logic [31:0] val, input logic sos);
    scan_step_t s;
    s = '0;
    s.val = val;
    s.sos = sos;
    return s;
  endfunction

  function automatic scan_step_t pix_known(input logic [31:0] val, input logic sos,
                                           input logic [rbl3_pkg::OUT_LBL_W-1:0] lbl,
                                           input logic fresh, input logic ovf);
    scan_step_t s;
    s = pix_step(val, sos);
    s.typed = 1'b1;
    s.lbl = lbl;
    s.fresh = fresh;
    s.ovf = ovf;
    return s;
  endfunction

  function automatic void add_step(input scan_step_t s);
    scan_steps = {scan_steps, s};
  endfunction

  task automatic queue_pixel(input logic [31:0] val, input logic sos, input logic typed,
                             input rbl3_pkg::out_beat_t want);
    pixel_job_t j;
    j.beat.pixel_value = val;
    j.beat.start_of_scan = sos;
    j.typed = typed;
    j.want = want;
    pixel_q = {pixel_q, j};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || pending_labels.size() != 0);
  endtask

  task automatic write_reg(input logic [rbl3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      rbl3_pkg::REG_THRESHOLD: fg_threshold = val;
      rbl3_pkg::REG_COLS: cols_reg = val[rbl3_pkg::DIM_W-1:0];
      rbl3_pkg::REG_ROWS: rows_reg = val[rbl3_pkg::DIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic flag(input string what, input logic [31:0] e, input logic [31:0] g);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, e, g);
  endtask

  task automatic check_labels(input rbl3_pkg::out_beat_t want,
                              input rbl3_pkg::out_beat_t got);
    if (got.pixel_label !== want.pixel_label)
      flag("pixel_label", 32'(want.pixel_label), 32'(got.pixel_label));
    if (got.is_new_label !== want.is_new_label)
      flag("is_new_label", 32'(want.is_new_label), 32'(got.is_new_label));
    if (got.pair_count !== want.pair_count)
      flag("pair_count", 32'(want.pair_count), 32'(got.pair_count));
    if (got.pair0_high !== want.pair0_high)
      flag("pair0_high", 32'(want.pair0_high), 32'(got.pair0_high));
    if (got.pair0_low !== want.pair0_low)
      flag("pair0_low", 32'(want.pair0_low), 32'(got.pair0_low));
    if (got.pair1_high !== want.pair1_high)
      flag("pair1_high", 32'(want.pair1_high), 32'(got.pair1_high));
    if (got.pair1_low !== want.pair1_low)
      flag("pair1_low", 32'(want.pair1_low), 32'(got.pair1_low));
    if (got.pair2_high !== want.pair2_high)
      flag("pair2_high", 32'(want.pair2_high), 32'(got.pair2_high));
    if (got.pair2_low !== want.pair2_low)
      flag("pair2_low", 32'(want.pair2_low), 32'(got.pair2_low));
    if (got.label_overflow !== want.label_overflow)
      flag("label_overflow", 32'(want.label_overflow), 32'(got.label_overflow));
  endtask

  // Pixel sender: bursts of random length separated by random gaps.
  pixel_job_t cur_job;
  rbl3_pkg::out_beat_t pred;
  int burst_left = 0;
  int gap_left = 0;
  logic nxt_valid;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pred = label_pixel(cur_job.beat);
        if (cur_job.typed)
          pred = cur_job.want;
        pending_labels = {pending_labels, pred};
      end
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          cur_job = pixel_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left = $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end
        in_valid <= nxt_valid;
        if (nxt_valid)
          in_data <= cur_job.beat;
      end
    end
  end

  // Result receiver: the stall mode is redrawn periodically at random; a requested hold-off wins.
  int rcv_cycle = 0;
  int rcv_mode = 0;
  int hold_left = 0;
  int hold_seen = 0;
  logic rdy;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_labels.size() == 0)
          flag("result beat with nothing expected, pixel_label", '0,
               32'(out_data.pixel_label));
        else
          check_labels(pending_labels.pop_front(), out_data);
      end
      rcv_cycle++;
      if (rcv_cycle % 64 == 0)
        rcv_mode = $urandom_range(0, 3);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rcv_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (rcv_cycle % 3 == 0);
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  initial begin
    int k, n, frame, density, random_sent;
    logic [rbl3_pkg::DIM_W-1:0] cols_pick, rows_pick;
    logic [31:0] thr_pick;
    scan_step_t s;
    rbl3_pkg::out_beat_t want;
    fg_threshold = rbl3_pkg::THRESHOLD_RESET;
    cols_reg = rbl3_pkg::DIM_W'(rbl3_pkg::MAX_COLS);
    rows_reg = rbl3_pkg::DIM_W'(rbl3_pkg::MAX_ROWS);
    left_lbl = '0;
    col_pos = '0;
    row_pos = '0;
    first_frame = 1'b1;
    label_ctr = '0;

    add_step(pix_known(32'h7FFF_FFFF, 1'b0, 16'd1, 1'b1, 1'b0));
    add_step(pix_known(32'h8000_0000, 1'b0, 16'd0, 1'b0, 1'b0));
    add_step(pix_known(32'h0003_0000, 1'b0, 16'd2, 1'b1, 1'b0));
    add_step(pix_known(32'h0002_FFFF, 1'b0, 16'd0, 1'b0, 1'b0));
    add_step(cfg_step(rbl3_pkg::REG_THRESHOLD, 32'h8000_0000));
    add_step(cfg_step(rbl3_pkg::REG_COLS, 32'd0));
    add_step(cfg_step(rbl3_pkg::REG_ROWS, 32'd2047));
    add_step(pix_known(32'h8000_0000, 1'b1, 16'd1, 1'b1, 1'b0));
    add_step(pix_step(32'h0000_0000, 1'b0));
    add_step(cfg_step(rbl3_pkg::REG_THRESHOLD, 32'h0001_0000));
    add_step(cfg_step(rbl3_pkg::REG_COLS, 32'd3));
    add_step(cfg_step(rbl3_pkg::REG_ROWS, 32'd2));
    add_step(pix_known(32'h0001_0000, 1'b1, 16'd1, 1'b1, 1'b0));
    add_step(pix_known(32'h0000_0000, 1'b0, 16'd0, 1'b0, 1'b0));
    add_step(pix_known(32'h7FFF_0000, 1'b0, 16'd2, 1'b1, 1'b0));
    add_step(pix_step(32'h0002_0000, 1'b0));
    add_step(pix_step(32'h0001_0000, 1'b0));
    add_step(pix_step(32'h0005_0000, 1'b0));
    add_step(pix_step(32'h0004_0000, 1'b0));
    add_step(pix_step(32'h0001_0001, 1'b0));
    add_step(pix_step(32'h0100_0000, 1'b0));
    add_step(pix_step(32'hFFFF_0000, 1'b0));
    add_step(pix_step(32'h0001_8000, 1'b0));
    add_step(pix_step(32'h0002_8000, 1'b0));
    // The column limit shrinks so that the current column lies past it while the first frame is under way.
    add_step(cfg_step(rbl3_pkg::REG_COLS, 32'd4));
    add_step(cfg_step(rbl3_pkg::REG_ROWS, 32'd3));
    add_step(pix_step(32'h0003_0000, 1'b1));
    add_step(pix_step(32'h0010_0000, 1'b0));
    add_step(cfg_step(rbl3_pkg::REG_COLS, 32'd2));
    add_step(pix_step(32'h0002_0000, 1'b0));
    add_step(pix_step(32'h0006_0000, 1'b0));
    add_step(pix_step(32'hFFFF_FFFF, 1'b0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (scan_steps[i]) begin
      s = scan_steps[i];
      if (s.is_cfg) begin
        wait_drained();
        write_reg(s.idx, s.val);
      end else begin
        want = '0;
        want.pixel_label = s.lbl;
        want.is_new_label = s.fresh;
        want.label_overflow = s.ovf;
        queue_pixel(s.val, s.sos, s.typed, want);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0: thr_pick = 32'h0000_0000;
        1: thr_pick = 32'h8000_0000;
        2: thr_pick = 32'h7FFF_FFFF;
        3: thr_pick = $urandom;
        default: thr_pick = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
      case ($urandom_range(0, 9))
        0: begin
          cols_pick = rbl3_pkg::DIM_W'(rbl3_pkg::MAX_COLS);
          rows_pick = rbl3_pkg::DIM_W'($urandom_range(1, 2));
        end
        1: begin
          cols_pick = rbl3_pkg::DIM_W'($urandom_range(1, 2));
          rows_pick = rbl3_pkg::DIM_W'(rbl3_pkg::MAX_ROWS);
        end
        2: begin
          cols_pick = $urandom_range(0, 1) ? '0 :
                      rbl3_pkg::DIM_W'($urandom_range(1025, 2047));
          rows_pick = rbl3_pkg::DIM_W'($urandom_range(0, 5));
        end
        default: begin
          cols_pick = rbl3_pkg::DIM_W'($urandom_range(1, 8));
          rows_pick = rbl3_pkg::DIM_W'($urandom_range(1, 6));
        end
      endcase
      write_reg(rbl3_pkg::REG_THRESHOLD, thr_pick);
      write_reg(rbl3_pkg::REG_COLS, 32'(cols_pick));
      write_reg(rbl3_pkg::REG_ROWS, 32'(rows_pick));
      frame = dim_eff(cols_reg, rbl3_pkg::MAX_COLS) * dim_eff(rows_reg, rbl3_pkg::MAX_ROWS);
      n = frame * $urandom_range(2, 4);
      if (n > 300) n = 300;
      if (n < 12) n = 12;
      if (random_sent == 0) begin
        n = 250;
        hold_asks <= hold_asks + 1;
      end
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      density = $urandom_range(15, 90);
      for (k = 0; k < n; k++)
        queue_pixel(pick_pixel($urandom_range(1, 100) <= density),
                    k == 0 || $urandom_range(0, 149) == 0, 1'b0, '0);
      random_sent += n;
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_cnt == 0 && pending_labels.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
hdl/rbl3_pkg.sv
hdl/rbl3_ram.sv
hdl/rbl3_scan.sv
hdl/rbl3_label.sv
hdl/raster_blob_labeler_3d_unit.sv
sim/raster_blob_labeler_3d_unit_tb.sv
